// ===== rtl/core/response_frame_checker_core_assert.svh =====
// Assertion macros shared by the response frame checker RTL.
`ifndef RESPONSE_FRAME_CHECKER_CORE_ASSERT_SVH
`define RESPONSE_FRAME_CHECKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rfc_pkg.sv =====
// Types and constants of the response frame checker.
package rfc_pkg;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_SHORT    = 3'd1,
    VERDICT_MARKER   = 3'd2,
    VERDICT_STATUS   = 3'd3,
    VERDICT_CHECKSUM = 3'd4
  } verdict_e;

  localparam logic [7:0] START_MARK    = 8'hDD;
  localparam logic [7:0] END_MARK      = 8'h77;
  localparam logic [2:0] COUNT_MAX     = 3'd7;
  localparam logic [2:0] MIN_LAST_IDX  = 3'd6;
  localparam logic [2:0] SUM_START_IDX = 3'd5;
  localparam logic [2:0] LAST_HDR_IDX  = 3'd3;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  command_byte;
    logic [7:0]  status_byte;
    logic [7:0]  payload_length;
    logic [15:0] received_checksum;
    logic [15:0] computed_checksum;
  } result_t;

endpackage

// ===== rtl/core/rfc_in_reg.sv =====
// Input register stage holding one received byte item.
module rfc_in_reg
  import rfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     take_i,
  output logic     item_valid_o,
  output in_item_t item_o
);

  logic     vld_q, vld_d;
  in_item_t item_q;

  assign in_ready_o = !vld_q || take_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/core/rfc_frame_state.sv =====
// Per-frame state, running checksum and verdict logic.
module rfc_frame_state
  import rfc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_item_t item_i,
  output result_t  result_o
);

  logic [2:0]       count_q, count_d;
  logic [7:0]       first_q, first_d;
  logic [2:0][7:0]  hdr_q, hdr_d;
  logic [15:0]      sum_q, sum_d;
  logic [2:0][7:0]  tail_q, tail_d;
  logic [1:0]       hdr_idx;
  logic [15:0]      rx_sum;
  logic [15:0]      calc_sum;
  logic             short_frame;
  verdict_e         verdict;

  assign hdr_idx = count_q[1:0] - 2'd1;

  always_comb begin
    first_d = first_q;
    hdr_d   = hdr_q;
    if (count_q == 3'd0) begin
      first_d = item_i.rx_byte;
    end else if (count_q <= LAST_HDR_IDX) begin
      hdr_d[hdr_idx] = item_i.rx_byte;
    end
    sum_d = sum_q;
    if (count_q >= SUM_START_IDX) begin
      sum_d = sum_q + {8'h00, tail_q[2]};
    end
    tail_d  = {tail_q[1], tail_q[0], item_i.rx_byte};
    count_d = (count_q == COUNT_MAX) ? count_q : count_q + 3'd1;
  end

  assign short_frame = count_q < MIN_LAST_IDX;
  assign rx_sum      = {tail_q[1], tail_q[0]};
  assign calc_sum    = 16'h0000 - sum_d;

  always_comb begin
    priority if (short_frame) begin
      verdict = VERDICT_SHORT;
    end else if (first_d != START_MARK || item_i.rx_byte != END_MARK) begin
      verdict = VERDICT_MARKER;
    end else if (hdr_d[1] != 8'h00) begin
      verdict = VERDICT_STATUS;
    end else if (rx_sum != calc_sum) begin
      verdict = VERDICT_CHECKSUM;
    end else begin
      verdict = VERDICT_OK;
    end
  end

  always_comb begin
    result_o.verdict           = verdict;
    result_o.command_byte      = hdr_d[0];
    result_o.status_byte       = hdr_d[1];
    result_o.payload_length    = hdr_d[2];
    result_o.received_checksum = short_frame ? 16'h0000 : rx_sum;
    result_o.computed_checksum = short_frame ? 16'h0000 : calc_sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      first_q <= '0;
      hdr_q   <= '0;
      sum_q   <= '0;
      tail_q  <= '0;
    end else if (step_i) begin
      if (item_i.frame_end) begin
        count_q <= '0;
        first_q <= '0;
        hdr_q   <= '0;
        sum_q   <= '0;
        tail_q  <= '0;
      end else begin
        count_q <= count_d;
        first_q <= first_d;
        hdr_q   <= hdr_d;
        sum_q   <= sum_d;
        tail_q  <= tail_d;
      end
    end
  end

  `include "response_frame_checker_core_assert.svh"

  `RFC_ASSERT_NEXT(a_clear_after_end, step_i && item_i.frame_end, count_q == 3'd0 && sum_q == 16'h0000, "Frame state not cleared after the final byte.")
  `RFC_ASSERT_NOW(a_sum_idle_early, count_q < 3'd6, sum_q == 16'h0000, "Checksum accumulated before the first counted byte left the delay line.")

endmodule

// ===== rtl/core/rfc_result_fifo.sv =====
// Two-entry result buffer between the verdict logic and the output channel.
module rfc_result_fifo
  import rfc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o      = cnt_q == 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign data_o      = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `include "response_frame_checker_core_assert.svh"

  `RFC_ASSERT_NOW(a_no_push_full, push_i, !full_o, "Result pushed into a full buffer.")
  `RFC_ASSERT_NOW(a_count_range, 1'b1, cnt_q <= 2'd2, "Result buffer count out of range.")
  `RFC_ASSERT_NEXT(a_count_grow, push_i && !pop, cnt_q == $past(cnt_q) + 2'd1, "Result buffer count did not grow on a push.")

endmodule

// ===== rtl/core/response_frame_checker_core.sv =====
// The final byte item passes the input register and its verdict passes the result buffer before it is offered.
// Throughput: one byte item per cycle, except while a final byte item waits for space in a full result buffer.
// A two-entry result buffer keeps input flowing while a verdict waits at the output.
// Reset: rst_ni is asynchronous and active low; it clears all frame state and the buffer.
// Top level of the response frame checker.
module response_frame_checker_core
  import rfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  verdict_o,
  output logic [7:0]  command_byte_o,
  output logic [7:0]  status_byte_o,
  output logic [7:0]  payload_length_o,
  output logic [15:0] received_checksum_o,
  output logic [15:0] computed_checksum_o
);

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     take;
  logic     fifo_full;
  result_t  result;
  result_t  out_data;

  assign in_item.rx_byte   = rx_byte_i;
  assign in_item.frame_end = frame_end_i;

  assign take = item_valid && (!item.frame_end || !fifo_full);

  rfc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  rfc_frame_state u_frame_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (take),
    .item_i   (item),
    .result_o (result)
  );

  rfc_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take && item.frame_end),
    .data_i      (result),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_data)
  );

  assign verdict_o           = out_data.verdict;
  assign command_byte_o      = out_data.command_byte;
  assign status_byte_o       = out_data.status_byte;
  assign payload_length_o    = out_data.payload_length;
  assign received_checksum_o = out_data.received_checksum;
  assign computed_checksum_o = out_data.computed_checksum;

endmodule
